@@ sv/bol_pkg.sv @@
package bol_pkg;

  // request action codes
  typedef enum logic [2:0] {
    ACT_INS_HEAD  = 3'd0,
    ACT_DEL_HEAD  = 3'd1,
    ACT_INS_AFTER = 3'd2,
    ACT_DEL_AFTER = 3'd3,
    ACT_READOUT   = 3'd4
  } action_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_NOSUCC   = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_READ
  } state_t;

  // command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INS_HEAD,
    CMD_DEL_HEAD,
    CMD_ROT,
    CMD_START,
    CMD_ADV,
    CMD_INS_AFTER,
    CMD_DEL_AFTER
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t  cmd;
    logic [7:0] value;
    logic [7:0] target;
  } cell_ctrl_t;

  typedef struct packed {
    logic tok;    // search token sits here
    logic hit;    // token on a valid entry equal to target
    logic stray;  // token past the tail
    logic succ;   // token entry has a successor
  } cell_flags_t;

  localparam logic [2:0] LIMIT_RESET = 3'd4;

endpackage

@@ sv/bounded_ordered_list.sv @@
// bounded ordered list of bytes, head first, held in a chain of cells
//
// in_*  : one request per handshake, in_tdata = action, value, target
// out_* : results, out_tdata = status, entry, count; out_tlast marks the
//         final result of a request
// cfg_* : size limit register, written whenever cfg_wr_en is high
//
// requests are taken one at a time; in_tready is high only while no request
// is in progress. a result already in the output register may still wait
// for out_tready while the next request is taken.
// head insert/delete and unused actions give their result from the execute
// state; insert/delete after target first drop a search token into cell 0,
// which steps one cell per cycle until it sits on a matching entry or runs
// past the tail when no entry matches; a readout gives one entry per cycle
// while the receiver takes them, as the list rotates past cell 0, and the
// list is whole again after the last entry.
// reset empties the list and sets the limit to 4; the entry cells keep
// stale data. a stalled receiver holds the sequencer where a result is due
// until the output register drains; the list is never touched while waiting.
module bounded_ordered_list #(
  parameter int CAPACITY = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // action[2:0], value[10:3], target[18:11]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // status[2:0], entry[10:3], count[13:11]
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data  // size limit
);

  localparam int CW = $clog2(CAPACITY + 1);

  bol_pkg::state_t     state_r, state_nxt;
  logic [2:0]          act_r;
  logic [7:0]          val_r, tgt_r;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       rd_r, rd_nxt;
  logic [2:0]          lim_r;

  // output register
  logic                out_tvalid_r;
  logic [13:0]         out_data_r;
  logic                out_last_r;

  // chain wiring
  bol_pkg::cell_ctrl_t  ctrl;
  bol_pkg::cell_cmd_t   cmd;
  logic [7:0]           data_w [CAPACITY];
  bol_pkg::cell_flags_t flags_w [CAPACITY];

  logic any_tok, any_hit, any_stray, any_succ;
  logic full, can_emit, accept;

  // result being built this cycle
  logic                emit;
  bol_pkg::status_t    em_status;
  logic [7:0]          em_entry;
  logic                em_last;
  logic [CW+2:0]       cnt_ext;

  assign ctrl.cmd    = cmd;
  assign ctrl.value  = val_r;
  assign ctrl.target = tgt_r;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [7:0] prev_d, next_d;
      logic       prev_t;
      if (gi == 0) begin : g_first
        assign prev_d = 8'h00;
        assign prev_t = 1'b0;
      end else begin : g_mid
        assign prev_d = data_w[gi-1];
        assign prev_t = flags_w[gi-1].tok;
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign next_d = 8'h00;
      end else begin : g_inner
        assign next_d = data_w[gi+1];
      end
      bol_cell #(
        .IDX (gi),
        .CW  (CW)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cnt       (cnt_r),
        .prev_data (prev_d),
        .next_data (next_d),
        .head_data (data_w[0]),
        .prev_tok  (prev_t),
        .data      (data_w[gi]),
        .flags     (flags_w[gi])
      );
    end
  endgenerate

  // token status gathered over the chain
  always_comb begin
    any_tok   = 1'b0;
    any_hit   = 1'b0;
    any_stray = 1'b0;
    any_succ  = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_tok   = any_tok   | flags_w[i].tok;
      any_hit   = any_hit   | flags_w[i].hit;
      any_stray = any_stray | flags_w[i].stray;
      any_succ  = any_succ  | flags_w[i].succ;
    end
  end

  // limit above capacity acts as capacity
  assign full = ({3'b000, cnt_r} >= {{CW{1'b0}}, lim_r}) || (cnt_r == CW'(CAPACITY));
  assign can_emit  = ~out_tvalid_r | out_tready;
  assign in_tready = (state_r == bol_pkg::S_IDLE);
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = bol_pkg::CMD_HOLD;
    cnt_nxt   = cnt_r;
    rd_nxt    = rd_r;
    emit      = 1'b0;
    em_status = bol_pkg::ST_OK;
    em_entry  = 8'h00;
    em_last   = 1'b1;
    unique case (state_r)
      bol_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = bol_pkg::S_EXEC;
        end
      end
      bol_pkg::S_EXEC: begin
        case (act_r) inside
          bol_pkg::ACT_INS_HEAD: begin
            if (can_emit) begin
              emit      = 1'b1;
              state_nxt = bol_pkg::S_IDLE;
              if (full) begin
                em_status = bol_pkg::ST_FULL;
              end else begin
                cmd     = bol_pkg::CMD_INS_HEAD;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
          end
          bol_pkg::ACT_DEL_HEAD: begin
            if (can_emit) begin
              emit      = 1'b1;
              state_nxt = bol_pkg::S_IDLE;
              if (cnt_r == '0) begin
                em_status = bol_pkg::ST_EMPTY;
              end else begin
                cmd     = bol_pkg::CMD_DEL_HEAD;
                cnt_nxt = cnt_r - CW'(1);
              end
            end
          end
          bol_pkg::ACT_INS_AFTER, bol_pkg::ACT_DEL_AFTER: begin
            // drop the search token into the head cell
            cmd       = bol_pkg::CMD_START;
            state_nxt = bol_pkg::S_SCAN;
          end
          bol_pkg::ACT_READOUT: begin
            if (cnt_r == '0) begin
              if (can_emit) begin
                emit      = 1'b1;
                em_status = bol_pkg::ST_EMPTY;
                state_nxt = bol_pkg::S_IDLE;
              end
            end else begin
              rd_nxt    = '0;
              state_nxt = bol_pkg::S_READ;
            end
          end
          default: begin
            // unused action: plain ok with current count
            if (can_emit) begin
              emit      = 1'b1;
              state_nxt = bol_pkg::S_IDLE;
            end
          end
        endcase
      end
      bol_pkg::S_SCAN: begin
        if (~any_tok | any_stray) begin
          // token ran past the tail or off the chain
          if (can_emit) begin
            emit      = 1'b1;
            em_status = bol_pkg::ST_NOTFOUND;
            state_nxt = bol_pkg::S_IDLE;
          end
        end else if (any_hit) begin
          if (can_emit) begin
            emit      = 1'b1;
            state_nxt = bol_pkg::S_IDLE;
            if (act_r == bol_pkg::ACT_INS_AFTER) begin
              if (full) begin
                em_status = bol_pkg::ST_FULL;
              end else begin
                cmd     = bol_pkg::CMD_INS_AFTER;
                cnt_nxt = cnt_r + CW'(1);
              end
            end else begin
              if (any_succ) begin
                cmd     = bol_pkg::CMD_DEL_AFTER;
                cnt_nxt = cnt_r - CW'(1);
              end else begin
                em_status = bol_pkg::ST_NOSUCC;
              end
            end
          end
        end else begin
          cmd = bol_pkg::CMD_ADV;
        end
      end
      bol_pkg::S_READ: begin
        if (can_emit) begin
          // head cell goes out, list rotates, whole list restored at the end
          emit     = 1'b1;
          em_entry = data_w[0];
          em_last  = (rd_r + CW'(1)) == cnt_r;
          cmd      = bol_pkg::CMD_ROT;
          rd_nxt   = rd_r + CW'(1);
          if (em_last) begin
            state_nxt = bol_pkg::S_IDLE;
          end
        end
      end
      default: state_nxt = bol_pkg::S_IDLE;
    endcase
  end

  assign cnt_ext = {3'b000, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bol_pkg::S_IDLE;
      cnt_r   <= '0;
      rd_r    <= '0;
      lim_r   <= bol_pkg::LIMIT_RESET;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rd_r    <= rd_nxt;
      if (cfg_wr_en) begin
        lim_r <= cfg_wr_data;
      end
    end
  end

  // request fields
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_tdata[2:0];
      val_r <= in_tdata[10:3];
      tgt_r <= in_tdata[18:11];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {cnt_ext[2:0], em_entry, em_status};
      out_last_r <= em_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_data_r};
  assign out_tlast  = out_last_r;

endmodule

@@ sv/bol_cell.sv @@
module bol_cell #(
  parameter int IDX = 0,
  parameter int CW  = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bol_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]       cnt,
  input  logic [7:0]          prev_data,
  input  logic [7:0]          next_data,
  input  logic [7:0]          head_data,
  input  logic                prev_tok,
  output logic [7:0]          data,
  output bol_pkg::cell_flags_t flags
);

  localparam logic IS_HEAD = (IDX == 0);

  logic [7:0] data_r, data_nxt;
  logic       tok_r, tok_nxt;
  logic       passed_r, passed_nxt;
  logic       valid, valid_next, tail, beyond;

  assign valid      = cnt > CW'(IDX);
  assign valid_next = cnt > CW'(IDX + 1);
  assign tail       = cnt == CW'(IDX + 1);
  assign beyond     = ~tok_r & ~passed_r;

  always_comb begin
    data_nxt   = data_r;
    tok_nxt    = tok_r;
    passed_nxt = passed_r;
    case (ctrl.cmd)
      bol_pkg::CMD_INS_HEAD: data_nxt = IS_HEAD ? ctrl.value : prev_data;
      bol_pkg::CMD_DEL_HEAD: data_nxt = next_data;
      bol_pkg::CMD_ROT:      data_nxt = tail ? head_data : next_data;
      bol_pkg::CMD_START: begin
        tok_nxt    = IS_HEAD;
        passed_nxt = 1'b0;
      end
      bol_pkg::CMD_ADV: begin
        tok_nxt    = prev_tok;
        passed_nxt = passed_r | tok_r;
      end
      bol_pkg::CMD_INS_AFTER: begin
        if (prev_tok) begin
          data_nxt = ctrl.value;
        end else if (beyond) begin
          data_nxt = prev_data;
        end
      end
      bol_pkg::CMD_DEL_AFTER: data_nxt = beyond ? next_data : data_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r    <= 1'b0;
      passed_r <= 1'b0;
    end else begin
      tok_r    <= tok_nxt;
      passed_r <= passed_nxt;
    end
  end

  assign data        = data_r;
  assign flags.tok   = tok_r;
  assign flags.hit   = tok_r & valid & (data_r == ctrl.target);
  assign flags.stray = tok_r & ~valid;
  assign flags.succ  = tok_r & valid_next;

endmodule

@@ sv/bol_checker.sv @@
module bol_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // any failure status is a single, final result
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] != bol_pkg::ST_OK) |-> out_tlast)
    else $error("failure status without last mark");

  // entry field is only used by readout results
  a_err_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] != bol_pkg::ST_OK) |-> out_tdata[10:3] == 8'h00)
    else $error("failure status with nonzero entry");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in progress");

endmodule

bind bounded_ordered_list bol_checker u_bol_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
